// File: src/mttc_pkg.sv
package mttc_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned SCREENS = 4;

  // Derived sizes of the cell memory and its counters.
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned DEPTH   = SCREENS * CELLS;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned OFF_W   = $clog2(CELLS);
  localparam int unsigned SCR_W   = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int unsigned BLK_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Field widths of the channels.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned TERM_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned ATTR_W  = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWITCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Character codes and reset values.
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CELL_W-1:0] CELL_RESET   = 16'h0F20;

  typedef logic [CELL_W-1:0] cell_t;

endpackage

// File: src/multi_terminal_text_console.sv
// Text console with several screens of 25 rows by 80 cells, all kept in one synchronous
// cell memory with a per-screen row base that rotates on scroll. After reset the block
// fills every cell with a space on attribute 0x0F and stalls its input channel
// meanwhile; configuration writes are taken at any time. A put, switch or read item
// then passes from acceptance through address calculation and one memory access to its
// result beat, which waits while the output is stalled; a put that scrolls also blanks
// the new bottom row, cell by cell, through the single memory write port before its
// result. Items are handled one at a time; a finished result waits in the output
// register while the next item is accepted.
module multi_terminal_text_console (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mttc_pkg::CMD_W-1:0]    in_cmd,
  input  logic [mttc_pkg::TERM_W-1:0]   in_terminal,
  input  logic [mttc_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [mttc_pkg::INDEX_W-1:0]  in_cell_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mttc_pkg::CELL_W-1:0]   out_read_data,
  output logic [mttc_pkg::TERM_W-1:0]   out_active_terminal,
  output logic [mttc_pkg::COL_W-1:0]    out_cursor_column,
  output logic [mttc_pkg::ROW_W-1:0]    out_cursor_row,
  output logic                          out_scrolled,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mttc_pkg::ATTR_W-1:0]   cfg_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_MEM   = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam int unsigned ADDR_W = mttc_pkg::ADDR_W;
  localparam int unsigned OFF_W  = mttc_pkg::OFF_W;
  localparam int unsigned SCR_W  = mttc_pkg::SCR_W;
  localparam int unsigned BLK_W  = mttc_pkg::BLK_W;
  localparam int unsigned COL_W  = mttc_pkg::COL_W;
  localparam int unsigned ROW_W  = mttc_pkg::ROW_W;

  logic [2:0]                      state_r, state_nxt;
  logic [ADDR_W-1:0]               clr_cnt_r;
  logic [mttc_pkg::ATTR_W-1:0]     attr_r;
  logic [mttc_pkg::TERM_W-1:0]     shown_r;
  logic [COL_W-1:0]                col_r  [mttc_pkg::SCREENS];
  logic [ROW_W-1:0]                row_r  [mttc_pkg::SCREENS];
  logic [OFF_W-1:0]                base_r [mttc_pkg::SCREENS];

  // Item held while it is worked on.
  logic [mttc_pkg::CMD_W-1:0]      cmd_r;
  logic [mttc_pkg::TERM_W-1:0]     term_r;
  logic [mttc_pkg::CHAR_W-1:0]     char_r;
  logic [mttc_pkg::INDEX_W-1:0]    idx_r;
  logic                            valid_r;
  logic [ADDR_W-1:0]               scr_base_r;
  logic [OFF_W-1:0]                phys_r;
  logic                            wr_en_r;
  logic                            rd_en_r;
  mttc_pkg::cell_t                 wdata_r;
  logic                            scroll_r;
  logic [ADDR_W-1:0]               blk_addr_r;
  logic [BLK_W-1:0]                blk_cnt_r;
  mttc_pkg::cell_t                 rd_q_r;

  // Output register.
  logic                            out_valid_r;
  mttc_pkg::cell_t                 out_read_data_r;
  logic [mttc_pkg::TERM_W-1:0]     out_active_r;
  logic [COL_W-1:0]                out_col_r;
  logic [ROW_W-1:0]                out_row_r;
  logic                            out_scrolled_r;

  mttc_pkg::cell_t                 mem [mttc_pkg::DEPTH];

  logic [SCR_W-1:0]                sidx;
  logic [COL_W-1:0]                cur_col;
  logic [ROW_W-1:0]                cur_row;
  logic                            is_put;
  logic [COL_W-1:0]                put_col;
  logic [ROW_W:0]                  put_row;
  logic [COL_W-1:0]                wr_col;
  logic                            wr_need;
  logic [mttc_pkg::CHAR_W-1:0]     wr_char;
  logic                            scroll_need;
  logic [OFF_W-1:0]                lin;
  logic [OFF_W:0]                  phys_sum;
  logic [OFF_W-1:0]                phys_wrap;
  logic [OFF_W:0]                  base_sum;
  logic [OFF_W-1:0]                base_wrap;
  logic                            out_free;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  mttc_pkg::cell_t                 mem_wdata;
  logic                            mem_re;
  logic [ADDR_W-1:0]               mem_raddr;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign sidx    = SCR_W'(term_r);
  assign cur_col = col_r[sidx];
  assign cur_row = row_r[sidx];
  assign is_put  = valid_r && (cmd_r == mttc_pkg::CMD_PUT);

  // Cursor movement and the cell that a put writes.
  always_comb begin
    put_col = cur_col;
    put_row = {1'b0, cur_row};
    wr_col  = cur_col;
    wr_need = 1'b0;
    wr_char = char_r;
    if (char_r == mttc_pkg::CH_NEWLINE) begin
      put_col = '0;
      put_row = {1'b0, cur_row} + (ROW_W+1)'(1);
    end else if (char_r == mttc_pkg::CH_BACKSPACE) begin
      if (cur_col != '0) begin
        put_col = cur_col - COL_W'(1);
        wr_col  = cur_col - COL_W'(1);
        wr_need = 1'b1;
        wr_char = mttc_pkg::CH_SPACE;
      end
    end else begin
      wr_need = 1'b1;
      if (32'(cur_col) + 32'd1 >= mttc_pkg::COLUMNS) begin
        put_col = '0;
        put_row = {1'b0, cur_row} + (ROW_W+1)'(1);
      end else begin
        put_col = cur_col + COL_W'(1);
      end
    end
    scroll_need = (32'(put_row) >= mttc_pkg::ROWS);
  end

  // Logical cell offset, rotated by the screen's row base into a physical offset.
  always_comb begin
    if (cmd_r == mttc_pkg::CMD_READ) begin
      lin = OFF_W'(idx_r);
    end else begin
      lin = OFF_W'(cur_row) * OFF_W'(mttc_pkg::COLUMNS) + OFF_W'(wr_col);
    end
    phys_sum = (OFF_W+1)'(lin) + (OFF_W+1)'(base_r[sidx]);
    if (32'(phys_sum) >= mttc_pkg::CELLS) begin
      phys_wrap = OFF_W'(phys_sum - (OFF_W+1)'(mttc_pkg::CELLS));
    end else begin
      phys_wrap = OFF_W'(phys_sum);
    end
    base_sum = (OFF_W+1)'(base_r[sidx]) + (OFF_W+1)'(mttc_pkg::COLUMNS);
    if (32'(base_sum) >= mttc_pkg::CELLS) begin
      base_wrap = OFF_W'(base_sum - (OFF_W+1)'(mttc_pkg::CELLS));
    end else begin
      base_wrap = OFF_W'(base_sum);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(mttc_pkg::DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_CALC;
      end
      S_CALC: state_nxt = S_MEM;
      S_MEM: begin
        state_nxt = scroll_r ? S_BLANK : S_DONE;
      end
      S_BLANK: begin
        if (blk_cnt_r == BLK_W'(mttc_pkg::COLUMNS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scr_base_r + ADDR_W'(phys_r);
    mem_wdata = wdata_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = mttc_pkg::CELL_RESET;
      end
      S_MEM: mem_we = wr_en_r;
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = blk_addr_r;
        mem_wdata = {attr_r, mttc_pkg::CH_SPACE};
      end
      default: mem_we = 1'b0;
    endcase
    mem_re    = (state_r == S_MEM) && rd_en_r;
    mem_raddr = scr_base_r + ADDR_W'(phys_r);
  end

  // Cell memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q_r <= mem[mem_raddr];
    end
  end

  // Control state, cursors and row bases.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      attr_r    <= mttc_pkg::ATTR_RESET;
      shown_r   <= '0;
      for (int i = 0; i < int'(mttc_pkg::SCREENS); i++) begin
        col_r[i]  <= '0;
        row_r[i]  <= '0;
        base_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) attr_r <= cfg_data;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (state_r == S_CALC) begin
        if (is_put) begin
          col_r[sidx] <= put_col;
          row_r[sidx] <= scroll_need ? ROW_W'(mttc_pkg::ROWS - 1) : ROW_W'(put_row);
        end
        if (valid_r && (cmd_r == mttc_pkg::CMD_SWITCH)) shown_r <= term_r;
      end
      if ((state_r == S_MEM) && scroll_r) base_r[sidx] <= base_wrap;
    end
  end

  // Item registers along the sequence.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cmd_r      <= in_cmd;
        term_r     <= in_terminal;
        char_r     <= in_char_code;
        idx_r      <= in_cell_index;
        valid_r    <= (32'(in_terminal) < mttc_pkg::SCREENS);
        scr_base_r <= ADDR_W'(in_terminal) * ADDR_W'(mttc_pkg::CELLS);
      end
      S_CALC: begin
        phys_r   <= phys_wrap;
        wr_en_r  <= is_put && wr_need;
        rd_en_r  <= valid_r && (cmd_r == mttc_pkg::CMD_READ)
                    && (32'(idx_r) < mttc_pkg::CELLS);
        wdata_r  <= {attr_r, wr_char};
        scroll_r <= is_put && scroll_need;
      end
      S_MEM: begin
        // The old top row becomes the new bottom row.
        blk_addr_r <= scr_base_r + ADDR_W'(base_r[sidx]);
        blk_cnt_r  <= '0;
      end
      S_BLANK: begin
        blk_addr_r <= blk_addr_r + ADDR_W'(1);
        blk_cnt_r  <= blk_cnt_r + BLK_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_read_data_r <= rd_en_r ? rd_q_r : '0;
      out_active_r    <= shown_r;
      out_col_r       <= valid_r ? cur_col : '0;
      out_row_r       <= valid_r ? cur_row : '0;
      out_scrolled_r  <= scroll_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_read_data_r;
  assign out_active_terminal = out_active_r;
  assign out_cursor_column   = out_col_r;
  assign out_cursor_row      = out_row_r;
  assign out_scrolled        = out_scrolled_r;

  // The reported cursor always lies on the screen.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_row) < mttc_pkg::ROWS))
    else $error("cursor row beyond last row");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_column) < mttc_pkg::COLUMNS))
    else $error("cursor column beyond last column");

  // An accepted beat starts the address calculation in the next cycle.
  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CALC))
    else $error("accepted beat not processed");

  // Row blanking only runs for a put that scrolled.
  a_blank_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLANK) |-> (scroll_r && (cmd_r == mttc_pkg::CMD_PUT)))
    else $error("row blanking without a scroll");

endmodule
